// ----- rtl/tli_pkg.sv -----
// Package for the table linear interpolator: field widths, beat layout and codes.
// Shared by the top level; has no dependencies of its own.
// The RAM module is generic and does not import this package.
package tli_pkg;

    // Field widths of the stream beats.
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned VEL_W  = 16;
    localparam int unsigned DIST_W = 18;

    // Packed tdata widths, rounded up to whole bytes.
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 24;

    // Interpolation datapath: the weighted sum needs 34 bits, and the quotient
    // is known to fit the distance width.
    localparam int unsigned PROD_W    = 34;
    localparam int unsigned CNT_W     = 5;
    localparam logic [CNT_W-1:0] DIV_STEPS = 5'd18;

    // Kind of an input beat, carried in tuser.
    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

endpackage

// ----- rtl/tli_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for both columns of the interpolation table; no dependencies.
// Contents are undefined until written.
module tli_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 15
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/table_linear_interpolator.sv -----
// Piecewise linear interpolation over a table of velocity/distance pairs held in
// two small RAMs. A load beat (tuser low) writes one slot; a load to a slot at or
// beyond TABLE_ENTRIES is dropped. A query beat (tuser high) scans the slots from
// index 0 at one RAM read per cycle and stops at the first slot whose velocity is
// not below the query. If that slot is above the query and a slot below it was
// seen, it forms lo*(vhi-q) + hi*(q-vlo) with one shared 18x16 multiplier, lo term
// first, and divides by vhi-vlo with an 18-step restoring divider. An exact match
// gives that slot's distance, a query above every slot gives the last slot's
// distance, and a query below every slot gives zero. A result that finds the output
// register still holding an untaken beat waits for it. Loads and queries are taken
// only while no query is in progress, so table reads and writes never overlap.
// A finished result waits in an output register while the next beat is accepted.
// Depends on tli_pkg and tli_ram.
module table_linear_interpolator
    import tli_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 15
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream.
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata, lowest bit up: entry_index[3:0], entry_velocity[15:0],
    // entry_distance[17:0], query_velocity[15:0], zero fill.
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: func (0 = load, 1 = query).
    input  logic                 i_s_tuser,
    // Result stream.
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // tdata, lowest bit up: halt_distance[17:0], zero fill.
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL_A,
        S_MUL_B,
        S_DIV,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_idx;
    logic                r_below;
    logic [VEL_W-1:0]    r_q;
    logic [VEL_W-1:0]    r_vlo;
    logic [VEL_W-1:0]    r_vhi;
    logic [DIST_W-1:0]   r_lo;
    logic [DIST_W-1:0]   r_hi;
    logic [PROD_W-1:0]   r_acc;
    logic [VEL_W-1:0]    r_den;
    logic [VEL_W-1:0]    r_rem;
    logic [DIST_W-1:0]   r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [DIST_W-1:0]   r_out_data;

    // Beat fields.
    logic [IDX_W-1:0]    w_entry_index;
    logic [VEL_W-1:0]    w_entry_velocity;
    logic [DIST_W-1:0]   w_entry_distance;
    logic [VEL_W-1:0]    w_query_velocity;
    t_func               w_func;
    logic                w_s_acc;

    assign w_entry_index    = i_s_tdata[3:0];
    assign w_entry_velocity = i_s_tdata[19:4];
    assign w_entry_distance = i_s_tdata[37:20];
    assign w_query_velocity = i_s_tdata[53:38];
    assign w_func           = t_func'(i_s_tuser);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    // Table RAM ports.
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;
    logic [VEL_W-1:0]    w_vel_rd;
    logic [DIST_W-1:0]   w_dist_rd;
    logic                w_last;

    assign w_last    = (r_idx == LAST_IDX);
    assign w_wr_en   = w_s_acc && (w_func == FUNC_LOAD)
                       && (32'(w_entry_index) < 32'(TABLE_ENTRIES));
    assign w_wr_addr = AW'(w_entry_index);

    // A query reads slot 0 on acceptance; the scan then reads ahead one slot a cycle.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if (w_s_acc && (w_func == FUNC_QUERY)) begin
            w_rd_en = 1'b1;
        end else if ((r_state == S_SCAN) && !w_last) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_idx + AW'(1);
        end
    end

    tli_ram #(
        .WIDTH (VEL_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_vel_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_entry_velocity),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_vel_rd)
    );

    tli_ram #(
        .WIDTH (DIST_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_dist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_entry_distance),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_dist_rd)
    );

    // Compare of the slot just read against the query.
    logic w_lt;
    logic w_gt;

    assign w_lt = (w_vel_rd < r_q);
    assign w_gt = (w_vel_rd > r_q);

    // Shared multiplier: lo*(vhi-q) first, then hi*(q-vlo).
    logic [DIST_W-1:0] w_mul_a;
    logic [VEL_W-1:0]  w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_sum;

    assign w_mul_a = (r_state == S_MUL_A) ? r_lo : r_hi;
    assign w_mul_b = (r_state == S_MUL_A) ? (r_vhi - r_q) : (r_q - r_vlo);
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_sum   = r_acc + w_prod;

    // One restoring division step; the partial remainder stays below the divisor.
    logic [VEL_W:0]   w_shift;
    logic [VEL_W:0]   w_diff;
    logic             w_ge;
    logic [VEL_W-1:0] n_rem;

    assign w_shift = {r_rem, r_quo[DIST_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};
    assign n_rem   = w_ge ? w_diff[VEL_W-1:0] : w_shift[VEL_W-1:0];

    // Sequencer, datapath registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // The output register fills from the emit state and drains on a taken beat.
            if ((r_state == S_EMIT) && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc && (w_func == FUNC_QUERY)) begin
                        r_q     <= w_query_velocity;
                        r_idx   <= '0;
                        r_below <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + AW'(1);
                    if (w_lt) begin
                        r_below <= 1'b1;
                        r_vlo   <= w_vel_rd;
                        r_lo    <= w_dist_rd;
                    end
                    if (w_gt) begin
                        r_vhi <= w_vel_rd;
                        r_hi  <= w_dist_rd;
                        if (r_below) begin
                            r_state <= S_MUL_A;
                        end else begin
                            // Nothing below the query before the stop.
                            r_quo   <= '0;
                            r_state <= S_EMIT;
                        end
                    end else if (!w_lt || w_last) begin
                        // Exact match, or the last slot lies below the query.
                        r_quo   <= w_dist_rd;
                        r_state <= S_EMIT;
                    end
                end
                S_MUL_A: begin
                    r_acc   <= w_prod;
                    r_den   <= r_vhi - r_vlo;
                    r_state <= S_MUL_B;
                end
                S_MUL_B: begin
                    r_rem   <= w_sum[PROD_W-1:DIST_W];
                    r_quo   <= w_sum[DIST_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[DIST_W-2:0], w_ge};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_STEPS - CNT_W'(1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_data  <= r_quo;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(M_TDATA_W - DIST_W)'(0), r_out_data};

    // The scan never runs past the last slot of the table.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= LAST_IDX))
        else $error("table scan index beyond last slot");

    // An accepted query always starts a scan in the next cycle.
    a_query_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (w_func == FUNC_QUERY)) |=> (r_state == S_SCAN))
        else $error("query accepted without starting a scan");

    // The divider step count stays within its range.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < DIV_STEPS))
        else $error("divider ran past its step count");

    // A result waiting on a stalled output register is not overwritten.
    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_out_valid && !i_m_tready) |=> (r_state == S_EMIT))
        else $error("result dropped while output stalled");

    // Table writes happen only when the block is idle, never under a scan.
    a_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_IDLE) && !w_rd_en)
        else $error("table write overlaps a query");

endmodule
